// File: hw/rtl/plap_pkg.sv
// plap_pkg: shared widths, register indexes, neighbor codes and the
// command/status structs used between the laplacian controller and datapath
// no dependencies
package plap_pkg;

  localparam int unsigned COORD_W   = 4;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned LAP_W     = 20;
  localparam int unsigned EXT_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DEF_MAX_DIM = 16;

  localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(16);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_I = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_J = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_K = 2'd2;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // which cell of the stencil is addressed
  typedef enum logic [2:0] {
    NB_CENTER = 3'd0,
    NB_I_NEXT = 3'd1,
    NB_I_PREV = 3'd2,
    NB_J_NEXT = 3'd3,
    NB_J_PREV = 3'd4,
    NB_K_NEXT = 3'd5,
    NB_K_PREV = 3'd6
  } nbr_e;

  typedef struct packed {
    logic load_item;
    logic mem_wr;
    logic rd_issue;
    nbr_e rd_sel;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_query;
    logic in_bad;
  } ctl_sts_t;

endpackage

// File: hw/rtl/plap_if.sv
// plap_in_if / plap_out_if: valid/ready channels carrying the item and result words
// depends on plap_pkg
interface plap_in_if import plap_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic        [COORD_W-1:0]  coord_i;
  logic        [COORD_W-1:0]  coord_j;
  logic        [COORD_W-1:0]  coord_k;
  logic signed [VALUE_W-1:0]  cell_value;

  modport source (output valid, opcode, coord_i, coord_j, coord_k, cell_value,
                  input ready);
  modport sink   (input valid, opcode, coord_i, coord_j, coord_k, cell_value,
                  output ready);
endinterface

interface plap_out_if import plap_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [LAP_W-1:0]  laplacian_value;
  logic                     index_error;

  modport source (output valid, laplacian_value, index_error, input ready);
  modport sink   (input valid, laplacian_value, index_error, output ready);
endinterface

// File: hw/rtl/plap_ctrl.sv
// plap_ctrl: sequencer for writes and seven-read queries, owns the output valid
// depends on plap_pkg
module plap_ctrl import plap_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_LAST,
    S_DONE
  } state_e;

  state_e state_q;
  nbr_e   nbr_q;
  logic   out_valid_q;
  logic   in_fire;
  logic   out_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;

  // commands to the datapath
  always_comb begin
    cmd_o.load_item = in_fire;
    cmd_o.mem_wr    = (state_q == S_WRITE);
    cmd_o.rd_issue  = (state_q == S_READ);
    cmd_o.rd_sel    = (state_q == S_READ) ? nbr_q : NB_CENTER;
    cmd_o.out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  end

  // state, neighbor counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nbr_q       <= NB_CENTER;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          nbr_q <= NB_CENTER;
          if (in_fire) begin
            if (sts_i.in_query) begin
              state_q <= sts_i.in_bad ? S_DONE : S_READ;
            end else begin
              state_q <= sts_i.in_bad ? S_IDLE : S_WRITE;
            end
          end
        end
        S_WRITE: begin
          state_q <= S_IDLE;
        end
        S_READ: begin
          if (nbr_q == NB_K_PREV) begin
            state_q <= S_LAST;
          end else begin
            nbr_q <= nbr_e'(nbr_q + 3'd1);
          end
        end
        S_LAST: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (cmd_o.out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // the memory port is never asked to write and read in one cycle
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_wr |-> !cmd_o.rd_issue)
    else $error("plap_ctrl: write and read issued together");

  // any word but an out-of-range write leaves the block busy in the cycle after it is taken
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (sts_i.in_query || !sts_i.in_bad) |=> !in_ready_o)
    else $error("plap_ctrl: ready right after accepting a word");

  // a result only appears out of the done state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("plap_ctrl: output valid raised outside done");

  // the final read is always followed by the done state
  a_last_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAST) |=> (state_q == S_DONE))
    else $error("plap_ctrl: last read not followed by done");

endmodule

// File: hw/rtl/plap_dp.sv
// plap_dp: extent registers, item latch, wrap logic, single-port grid memory,
// accumulator and output register of the laplacian block
// depends on plap_pkg
module plap_dp import plap_pkg::*; #(
  parameter int unsigned MAX_DIM_I = DEF_MAX_DIM,
  parameter int unsigned MAX_DIM_J = DEF_MAX_DIM,
  parameter int unsigned MAX_DIM_K = DEF_MAX_DIM
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic        [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [EXT_W-1:0]    cfg_data_i,
  input  logic                       opcode_i,
  input  logic        [COORD_W-1:0]  coord_i_i,
  input  logic        [COORD_W-1:0]  coord_j_i,
  input  logic        [COORD_W-1:0]  coord_k_i,
  input  logic signed [VALUE_W-1:0]  cell_value_i,
  input  ctl_cmd_t                   cmd_i,
  output ctl_sts_t                   sts_o,
  output logic signed [LAP_W-1:0]    laplacian_value_o,
  output logic                       index_error_o
);

  localparam int unsigned Depth = MAX_DIM_I * MAX_DIM_J * MAX_DIM_K;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CmpW  = EXT_W + 2;

  logic        [EXT_W-1:0]   size_i_q, size_j_q, size_k_q;
  logic        [EXT_W-1:0]   n_i, n_j, n_k;
  logic        [COORD_W-1:0] ci_q, cj_q, ck_q;
  logic signed [VALUE_W-1:0] val_q;
  logic                      bad_q;
  logic        [EXT_W-1:0]   i_next, i_prev, j_next, j_prev, k_next, k_prev;
  logic        [EXT_W-1:0]   ai, aj, ak;
  logic        [31:0]        addr_full;
  logic        [AddrW-1:0]   addr;
  logic        [VALUE_W-1:0] mem [Depth];
  logic        [VALUE_W-1:0] rd_q;
  logic                      pend_q;
  nbr_e                      sel_q;
  logic signed [LAP_W-1:0]   rd_ext;
  logic signed [LAP_W-1:0]   term;
  logic signed [LAP_W-1:0]   acc_q;
  logic signed [LAP_W-1:0]   lap_q;
  logic                      err_q;

  // extent registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_i_q <= EXT_RESET;
      size_j_q <= EXT_RESET;
      size_k_q <= EXT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SIZE_I: size_i_q <= cfg_data_i;
        REG_SIZE_J: size_j_q <= cfg_data_i;
        REG_SIZE_K: size_k_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // extents above the grid maximum act as the maximum
  assign n_i = ({2'b0, size_i_q} > CmpW'(MAX_DIM_I)) ? EXT_W'(MAX_DIM_I) : size_i_q;
  assign n_j = ({2'b0, size_j_q} > CmpW'(MAX_DIM_J)) ? EXT_W'(MAX_DIM_J) : size_j_q;
  assign n_k = ({2'b0, size_k_q} > CmpW'(MAX_DIM_K)) ? EXT_W'(MAX_DIM_K) : size_k_q;

  // status of the offered word
  assign sts_o.in_query = (opcode_i == OP_QUERY);
  assign sts_o.in_bad   = ({1'b0, coord_i_i} >= n_i) || ({1'b0, coord_j_i} >= n_j)
                       || ({1'b0, coord_k_i} >= n_k);

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      ci_q  <= coord_i_i;
      cj_q  <= coord_j_i;
      ck_q  <= coord_k_i;
      val_q <= cell_value_i;
      bad_q <= sts_o.in_bad;
    end
  end

  // periodic neighbor coordinates
  assign i_next = ({1'b0, ci_q} + 5'd1 == n_i) ? '0 : {1'b0, ci_q} + 5'd1;
  assign i_prev = (ci_q == '0) ? n_i - 5'd1 : {1'b0, ci_q} - 5'd1;
  assign j_next = ({1'b0, cj_q} + 5'd1 == n_j) ? '0 : {1'b0, cj_q} + 5'd1;
  assign j_prev = (cj_q == '0) ? n_j - 5'd1 : {1'b0, cj_q} - 5'd1;
  assign k_next = ({1'b0, ck_q} + 5'd1 == n_k) ? '0 : {1'b0, ck_q} + 5'd1;
  assign k_prev = (ck_q == '0) ? n_k - 5'd1 : {1'b0, ck_q} - 5'd1;

  // stencil cell select
  always_comb begin
    ai = {1'b0, ci_q};
    aj = {1'b0, cj_q};
    ak = {1'b0, ck_q};
    case (cmd_i.rd_sel)
      NB_I_NEXT: ai = i_next;
      NB_I_PREV: ai = i_prev;
      NB_J_NEXT: aj = j_next;
      NB_J_PREV: aj = j_prev;
      NB_K_NEXT: ak = k_next;
      NB_K_PREV: ak = k_prev;
      default: ;
    endcase
  end

  // fixed row-major layout over the maximum grid
  assign addr_full = ({27'b0, ai} * 32'(MAX_DIM_J) + {27'b0, aj}) * 32'(MAX_DIM_K)
                   + {27'b0, ak};
  assign addr      = addr_full[AddrW-1:0];

  // single-port grid memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[addr] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_q <= mem[addr];
    end
  end

  // read tracking, registered so that it lines up with the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      sel_q  <= NB_CENTER;
    end else begin
      pend_q <= cmd_i.rd_issue;
      sel_q  <= cmd_i.rd_sel;
    end
  end

  // centre weighs minus six, neighbors plus one
  assign rd_ext = {{(LAP_W-VALUE_W){rd_q[VALUE_W-1]}}, rd_q};
  assign term   = (sel_q == NB_CENTER) ? -((rd_ext <<< 2) + (rd_ext <<< 1)) : rd_ext;

  // accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      acc_q <= '0;
    end else if (pend_q) begin
      acc_q <= acc_q + term;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      lap_q <= bad_q ? '0 : acc_q;
      err_q <= bad_q;
    end
  end

  assign laplacian_value_o = lap_q;
  assign index_error_o     = err_q;

endmodule

// File: hw/rtl/periodic_laplacian_3d.sv
// periodic_laplacian_3d: seven-point periodic laplacian over a stored 3d grid
// sequence: an accepted write is then stored in the write state; an accepted query
// makes 7 reads on the single grid memory port, an accumulate step and an output load,
// which waits while the previous result is still held; a new word is taken only in idle;
// out-of-range queries go straight to the error result; out-of-range writes are dropped
// reset: extents return to 16, control idles; grid contents are undefined until written
// depends on plap_pkg, plap_if, plap_ctrl, plap_dp
module periodic_laplacian_3d import plap_pkg::*; #(
  parameter int unsigned MAX_DIM_I = DEF_MAX_DIM,
  parameter int unsigned MAX_DIM_J = DEF_MAX_DIM,
  parameter int unsigned MAX_DIM_K = DEF_MAX_DIM
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [EXT_W-1:0]      cfg_data_i,
  plap_in_if.sink               in_i,
  plap_out_if.source            out_o
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencer
  plap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath with grid memory
  plap_dp #(
    .MAX_DIM_I (MAX_DIM_I),
    .MAX_DIM_J (MAX_DIM_J),
    .MAX_DIM_K (MAX_DIM_K)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .opcode_i          (in_i.opcode),
    .coord_i_i         (in_i.coord_i),
    .coord_j_i         (in_i.coord_j),
    .coord_k_i         (in_i.coord_k),
    .cell_value_i      (in_i.cell_value),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .laplacian_value_o (out_o.laplacian_value),
    .index_error_o     (out_o.index_error)
  );

endmodule
